FILE: sv/blvp_pkg.sv
// ----------------------------------------------------------------------------
// blvp_pkg
// Types and constants shared by the low-battery protection controller.
// ----------------------------------------------------------------------------
`default_nettype none

package blvp_pkg;

    // Field widths.
    localparam int DelayW = 7;
    localparam int CurW   = 15;
    localparam int VoltW  = 13;
    localparam int ModeW  = 8;
    localparam int AlertW = 7;
    localparam int RecW   = 4;

    // Ramp and timer constants.
    localparam logic [AlertW-1:0] AlertTimerMax = 7'd127;
    localparam logic [RecW-1:0]   RisePeriod    = 4'd9;
    localparam logic [VoltW:0]    RiseVoltStep  = 14'd50;
    localparam logic [CurW:0]     RiseCurStep   = 16'd250;
    localparam logic [CurW-1:0]   DropCurStep   = 15'd250;
    localparam logic [CurW-1:0]   DropCurFloor  = 15'd750;
    localparam logic [VoltW-1:0]  DropVoltFloor = 13'd2750;
    localparam logic [VoltW-1:0]  DropVoltStep  = 13'd25;
    localparam logic [AlertW-1:0] RampFaultDelay = 7'd4;

    // Reset values of the configuration registers.
    localparam logic [DelayW-1:0] AlertDelayRst = 7'd20;
    localparam logic [DelayW-1:0] FaultDelayRst = 7'd4;
    localparam logic [CurW-1:0]   InitCurRst    = 15'd5000;
    localparam logic [VoltW-1:0]  InitVoltRst   = 13'd3000;

    // Event kinds.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_GEAR  = 2'd1,
        KIND_RAMP  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Result actions.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_OFF    = 2'd1,
        ACT_SWITCH = 2'd2
    } action_t;

    // Register indexes.
    typedef enum logic [1:0] {
        REG_ALERT_DELAY = 2'd0,
        REG_FAULT_DELAY = 2'd1,
        REG_INIT_CUR    = 2'd2,
        REG_INIT_VOLT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [DelayW-1:0] alert_delay;
        logic [DelayW-1:0] fault_delay;
        logic [CurW-1:0]   initial_current_limit;
        logic [VoltW-1:0]  initial_volt_threshold;
    } cfg_t;

    // Load strobes for the ramp state on a write of an initial value.
    typedef struct packed {
        logic             ld_cur;
        logic             ld_volt;
        logic [CurW-1:0]  cur_value;
        logic [VoltW-1:0] volt_value;
    } ramp_load_t;

    typedef struct packed {
        logic [AlertW-1:0] alert_timer;
        logic [RecW-1:0]   recovery_timer;
        logic [CurW-1:0]   ramp_current_limit;
        logic [VoltW-1:0]  ramp_volt_threshold;
    } state_t;

    typedef struct packed {
        kind_t            kind;
        logic             battery_alert;
        logic             battery_fault;
        logic             battery_ample;
        logic             key_pressed_event;
        logic             key_hold_event;
        logic             need_shutoff;
        logic [ModeW-1:0] jump_mode;
        logic [CurW-1:0]  mode_current_ma;
        logic [VoltW-1:0] mode_volt_threshold;
    } item_t;

    typedef struct packed {
        action_t          action;
        logic [ModeW-1:0] target_mode;
        logic [CurW-1:0]  current_limit_ma;
        logic [VoltW-1:0] volt_threshold_mv;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/battery_low_voltage_protector.sv
// ----------------------------------------------------------------------------
// battery_low_voltage_protector
// Low-battery protection controller for an LED driver.
// ----------------------------------------------------------------------------
// Events enter on the s_t* stream: tuser carries the event kind (tick, gear
// check, ramp check) and tdata the battery flags, key state and mode limits.
// Every event yields exactly one result on the m_t* stream: tuser carries the
// action (none, turn off, switch mode) and tdata the target mode and the
// present ramp current limit and voltage threshold.
// An event accepted into the input register is evaluated in a single pass
// of compare-and-update logic against the timer and ramp state, and lands
// in the result register when that register is free or drains. The
// throughput is one event per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its transaction and
// the input register still takes one more event; s_tready falls only when
// both are full. Configuration is to be written through the APB-style port
// only while the stream is idle, which the block does not enforce; writing
// an initial limit also reloads the ramp state.
// Reset clears both stages and the timers and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_low_voltage_protector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input events.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: battery_alert, battery_fault, battery_ample, key_pressed_event,
    // key_hold_event, need_shutoff, jump_mode[7:0], mode_current_ma[14:0],
    // mode_volt_threshold[12:0], zero fill
    input  wire logic [47:0] s_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]  s_tuser,
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: target_mode[7:0], current_limit_ma[14:0], volt_threshold_mv[12:0],
    // zero fill
    output logic [39:0]      m_tdata,
    // tuser: action[1:0]
    output logic [1:0]       m_tuser,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    blvp_pkg::cfg_t       cfg;
    blvp_pkg::ramp_load_t ramp_load;
    blvp_pkg::item_t      in_item;
    blvp_pkg::item_t      in_item_reg;
    logic                 in_valid_reg;
    blvp_pkg::state_t     st_reg;
    blvp_pkg::state_t     st_next;
    blvp_pkg::result_t    res_next;
    blvp_pkg::result_t    out_res_reg;
    logic                 out_valid_reg;
    logic                 advance;

    blvp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .ramp_load (ramp_load)
    );

    blvp_core u_core (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_item_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // Unpack the input transaction.
    assign in_item.kind                = blvp_pkg::kind_t'(s_tuser);
    assign in_item.battery_alert       = s_tdata[0];
    assign in_item.battery_fault       = s_tdata[1];
    assign in_item.battery_ample       = s_tdata[2];
    assign in_item.key_pressed_event   = s_tdata[3];
    assign in_item.key_hold_event      = s_tdata[4];
    assign in_item.need_shutoff        = s_tdata[5];
    assign in_item.jump_mode           = s_tdata[13:6];
    assign in_item.mode_current_ma     = s_tdata[28:14];
    assign in_item.mode_volt_threshold = s_tdata[41:29];

    // The input stage moves on when the result register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item;
        end
    end

    // Timer and ramp state; config loads apply only when no event advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.alert_timer         <= '0;
            st_reg.recovery_timer      <= '0;
            st_reg.ramp_current_limit  <= blvp_pkg::InitCurRst;
            st_reg.ramp_volt_threshold <= blvp_pkg::InitVoltRst;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
        else
        begin
            if (ramp_load.ld_cur)
            begin
                st_reg.ramp_current_limit <= ramp_load.cur_value;
            end
            if (ramp_load.ld_volt)
            begin
                st_reg.ramp_volt_threshold <= ramp_load.volt_value;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    // Pack the result transaction.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {4'd0, out_res_reg.volt_threshold_mv, out_res_reg.current_limit_ma,
                       out_res_reg.target_mode};

endmodule

`default_nettype wire

FILE: sv/blvp_regs.sv
// ----------------------------------------------------------------------------
// blvp_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module blvp_regs (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output blvp_pkg::cfg_t            cfg,
    output blvp_pkg::ramp_load_t      ramp_load
);

    blvp_pkg::cfg_t     cfg_reg;
    blvp_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = blvp_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes complete in the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alert_delay            <= blvp_pkg::AlertDelayRst;
            cfg_reg.fault_delay            <= blvp_pkg::FaultDelayRst;
            cfg_reg.initial_current_limit  <= blvp_pkg::InitCurRst;
            cfg_reg.initial_volt_threshold <= blvp_pkg::InitVoltRst;
        end
        else if (wr_en)
        begin
            unique case (idx)
                blvp_pkg::REG_ALERT_DELAY:
                    cfg_reg.alert_delay <= pwdata[blvp_pkg::DelayW-1:0];
                blvp_pkg::REG_FAULT_DELAY:
                    cfg_reg.fault_delay <= pwdata[blvp_pkg::DelayW-1:0];
                blvp_pkg::REG_INIT_CUR:
                    cfg_reg.initial_current_limit <= pwdata[blvp_pkg::CurW-1:0];
                blvp_pkg::REG_INIT_VOLT:
                    cfg_reg.initial_volt_threshold <= pwdata[blvp_pkg::VoltW-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A write of an initial value also reloads the matching ramp state.
    assign ramp_load.ld_cur     = wr_en && (idx == blvp_pkg::REG_INIT_CUR);
    assign ramp_load.ld_volt    = wr_en && (idx == blvp_pkg::REG_INIT_VOLT);
    assign ramp_load.cur_value  = pwdata[blvp_pkg::CurW-1:0];
    assign ramp_load.volt_value = pwdata[blvp_pkg::VoltW-1:0];

    // Read data.
    always_comb
    begin
        unique case (idx)
            blvp_pkg::REG_ALERT_DELAY:
                prdata = {25'd0, cfg_reg.alert_delay};
            blvp_pkg::REG_FAULT_DELAY:
                prdata = {25'd0, cfg_reg.fault_delay};
            blvp_pkg::REG_INIT_CUR:
                prdata = {17'd0, cfg_reg.initial_current_limit};
            blvp_pkg::REG_INIT_VOLT:
                prdata = {19'd0, cfg_reg.initial_volt_threshold};
            default:
                prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/blvp_core.sv
// ----------------------------------------------------------------------------
// blvp_core
// Single-pass event logic: timers, gear check and ramp check.
// ----------------------------------------------------------------------------
`default_nettype none

module blvp_core (
    input  blvp_pkg::cfg_t    cfg,
    input  blvp_pkg::state_t  st,
    input  blvp_pkg::item_t   item,
    output blvp_pkg::state_t  st_next,
    output blvp_pkg::result_t res
);

    always_comb
    begin
        logic [blvp_pkg::AlertW-1:0] at;
        logic [blvp_pkg::RecW-1:0]   rt;
        logic [blvp_pkg::CurW-1:0]   cur;
        logic [blvp_pkg::VoltW-1:0]  volt;
        logic [blvp_pkg::CurW:0]     cur_sum;
        logic [blvp_pkg::VoltW:0]    volt_sum;
        logic [blvp_pkg::DelayW-1:0] thr;
        logic                        changing;
        logic                        due;
        blvp_pkg::action_t           act;
        logic [blvp_pkg::ModeW-1:0]  target;

        at       = st.alert_timer;
        rt       = st.recovery_timer;
        cur      = st.ramp_current_limit;
        volt     = st.ramp_volt_threshold;
        cur_sum  = {1'b0, cur} + blvp_pkg::RiseCurStep;
        volt_sum = {1'b0, volt} + blvp_pkg::RiseVoltStep;
        thr      = cfg.alert_delay;
        changing = item.key_pressed_event && item.key_hold_event;
        due      = 1'b1;
        act      = blvp_pkg::ACT_NONE;
        target   = '0;

        unique case (item.kind)
            // Tick: both running timers advance up to their limits.
            blvp_pkg::KIND_TICK:
            begin
                if (rt != '0 && rt < blvp_pkg::RisePeriod)
                begin
                    rt = rt + 1'b1;
                end
                if (at != '0 && at <= cfg.alert_delay && at != blvp_pkg::AlertTimerMax)
                begin
                    at = at + 1'b1;
                end
            end

            // Gear check: step down on a lasting alert or fault, or turn off on a fault.
            blvp_pkg::KIND_GEAR:
            begin
                if (!item.battery_fault)
                begin
                    thr = cfg.alert_delay;
                    if (!item.battery_alert || changing)
                    begin
                        at = '0;
                    end
                    else if (at == '0)
                    begin
                        at = 7'd1;
                    end
                end
                else
                begin
                    thr = cfg.fault_delay;
                    if (at == '0)
                    begin
                        at = 7'd1;
                    end
                end
                if (item.need_shutoff || changing)
                begin
                    if (item.battery_fault && at > thr)
                    begin
                        act = blvp_pkg::ACT_OFF;
                    end
                end
                else if (at > thr)
                begin
                    at     = '0;
                    act    = blvp_pkg::ACT_SWITCH;
                    target = item.jump_mode;
                end
            end

            // Ramp check: lower or turn off on alert or fault; raise each eight ticks.
            blvp_pkg::KIND_RAMP:
            begin
                if (!item.battery_alert && !item.battery_fault)
                begin
                    at = '0;
                    if (item.battery_ample)
                    begin
                        if (cur < item.mode_current_ma)
                        begin
                            if (rt == '0)
                            begin
                                rt = 4'd1;
                            end
                            else if (rt < blvp_pkg::RisePeriod)
                            begin
                                due = 1'b0;
                            end
                            if (due)
                            begin
                                rt = 4'd1;
                                if (volt > item.mode_volt_threshold)
                                begin
                                    volt = item.mode_volt_threshold;
                                end
                                else if (volt_sum[blvp_pkg::VoltW])
                                begin
                                    volt = '1;
                                end
                                else
                                begin
                                    volt = volt_sum[blvp_pkg::VoltW-1:0];
                                end
                                if (cur_sum[blvp_pkg::CurW])
                                begin
                                    cur = '1;
                                end
                                else
                                begin
                                    cur = cur_sum[blvp_pkg::CurW-1:0];
                                end
                            end
                        end
                        else
                        begin
                            rt = '0;
                        end
                    end
                end
                else
                begin
                    rt = '0;
                    if (at == '0)
                    begin
                        at = 7'd1;
                    end
                    if (item.battery_fault && at > blvp_pkg::RampFaultDelay)
                    begin
                        act = blvp_pkg::ACT_OFF;
                    end
                    else if (at > cfg.alert_delay)
                    begin
                        if (cur > blvp_pkg::DropCurFloor)
                        begin
                            cur = cur - blvp_pkg::DropCurStep;
                        end
                        if (volt > blvp_pkg::DropVoltFloor)
                        begin
                            volt = volt - blvp_pkg::DropVoltStep;
                        end
                        at = 7'd1;
                    end
                end
            end

            default:
            begin
                act = blvp_pkg::ACT_NONE;
            end
        endcase

        st_next.alert_timer         = at;
        st_next.recovery_timer      = rt;
        st_next.ramp_current_limit  = cur;
        st_next.ramp_volt_threshold = volt;
        res.action                  = act;
        res.target_mode             = target;
        res.current_limit_ma        = cur;
        res.volt_threshold_mv       = volt;
    end

endmodule

`default_nettype wire

FILE: sv/blvp_checker.sv
// ----------------------------------------------------------------------------
// blvp_checker
// Port-level checks for the low-battery protection controller.
// ----------------------------------------------------------------------------
`default_nettype none

module blvp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // A stalled result holds its transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The action code is always one of the defined actions.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == blvp_pkg::ACT_NONE || m_tuser == blvp_pkg::ACT_OFF ||
                      m_tuser == blvp_pkg::ACT_SWITCH))
        else $error("undefined action code");

    // A target mode is reported only with a mode switch.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != blvp_pkg::ACT_SWITCH |-> m_tdata[7:0] == 8'd0)
        else $error("target mode without a switch");

    // Input back-pressure appears only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind battery_low_voltage_protector blvp_checker u_blvp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: dv/tb_battery_low_voltage_protector.sv
// ----------------------------------------------------------------------------
// tb_battery_low_voltage_protector
// Self-checking bench for the low-battery protection controller.
// ----------------------------------------------------------------------------
// Events are queued by the stimulus process and driven on the s_t* stream.
// Each accepted event runs through a behavioral copy of the timers and the
// ramp state, and the predicted verdict is queued. Every result on the m_t*
// stream is compared field by field with the oldest predicted verdict. The
// configuration registers are rewritten between phases, only while the
// stream is empty. The phases cover the reset defaults, a directed set of
// corner cases, short and long delays, extreme initial limits and random
// settings, while the sender and the receiver stall at changing rates.
// ----------------------------------------------------------------------------
module tb_battery_low_voltage_protector;
    timeunit 1ns;
    timeprecision 1ps;

    // Ramp and timer constants of the protection scheme.
    localparam int RiseTicks    = 9;
    localparam int RiseVolt     = 50;
    localparam int RiseCur      = 250;
    localparam int DropCur      = 250;
    localparam int DropCurMin   = 750;
    localparam int DropVoltMin  = 2750;
    localparam int DropVolt     = 25;
    localparam int RampFaultLag = 4;
    localparam int AlertCap     = 127;
    localparam int CurTop       = 32767;
    localparam int VoltTop      = 8191;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tdata: battery_alert, battery_fault, battery_ample, key_pressed_event,
    // key_hold_event, need_shutoff, jump_mode[7:0], mode_current_ma[14:0],
    // mode_volt_threshold[12:0], zero fill
    logic [47:0] s_tdata = '0;
    // tuser: kind[1:0]
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // tdata: target_mode[7:0], current_limit_ma[14:0], volt_threshold_mv[12:0],
    // zero fill
    logic [39:0] m_tdata;
    // tuser: action[1:0]
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Events waiting for the driver and verdicts waiting for the DUT.
    blvp_pkg::item_t   pending_events[$];
    blvp_pkg::result_t expected_verdicts[$];
    blvp_pkg::item_t   driven_event;
    int                mismatch_count = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;

    // Behavioral copy of the configuration and of the protection state.
    int cfg_alert_delay = 20;
    int cfg_fault_delay = 4;
    int alert_ticks = 0;
    int recovery_ticks = 0;
    int ramp_cur = 5000;
    int ramp_volt = 3000;

    battery_low_voltage_protector u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Applies one event to the protection state and returns its verdict.
    function automatic blvp_pkg::result_t predict_protection(blvp_pkg::item_t ev);
        blvp_pkg::result_t verdict;
        int                limit;
        bit                changing;
        bit                due;
        verdict.action = blvp_pkg::ACT_NONE;
        verdict.target_mode = '0;
        case (ev.kind)
            blvp_pkg::KIND_TICK:
            begin
                if (recovery_ticks > 0 && recovery_ticks < RiseTicks)
                    recovery_ticks++;
                if (alert_ticks > 0 && alert_ticks < cfg_alert_delay + 1
                    && alert_ticks < AlertCap)
                    alert_ticks++;
            end
            blvp_pkg::KIND_GEAR:
            begin
                changing = ev.key_pressed_event && ev.key_hold_event;
                if (!ev.battery_fault)
                begin
                    limit = cfg_alert_delay;
                    if (!ev.battery_alert || changing)
                        alert_ticks = 0;
                    else if (alert_ticks == 0)
                        alert_ticks = 1;
                end
                else
                begin
                    limit = cfg_fault_delay;
                    if (alert_ticks == 0)
                        alert_ticks = 1;
                end
                if (ev.need_shutoff || changing)
                begin
                    if (ev.battery_fault && alert_ticks > limit)
                        verdict.action = blvp_pkg::ACT_OFF;
                end
                else if (alert_ticks > limit)
                begin
                    alert_ticks = 0;
                    verdict.action = blvp_pkg::ACT_SWITCH;
                    verdict.target_mode = ev.jump_mode;
                end
            end
            blvp_pkg::KIND_RAMP:
            begin
                if (!ev.battery_alert && !ev.battery_fault)
                begin
                    alert_ticks = 0;
                    if (ev.battery_ample)
                    begin
                        if (ramp_cur < int'(ev.mode_current_ma))
                        begin
                            due = 1'b1;
                            if (recovery_ticks == 0)
                                recovery_ticks = 1;
                            else if (recovery_ticks < RiseTicks)
                                due = 1'b0;
                            if (due)
                            begin
                                recovery_ticks = 1;
                                // The threshold is clamped only once it is above
                                // the ceiling; the current may overshoot it.
                                if (ramp_volt > int'(ev.mode_volt_threshold))
                                    ramp_volt = int'(ev.mode_volt_threshold);
                                else
                                    ramp_volt = (ramp_volt + RiseVolt > VoltTop) ?
                                                VoltTop : ramp_volt + RiseVolt;
                                ramp_cur = (ramp_cur + RiseCur > CurTop) ?
                                           CurTop : ramp_cur + RiseCur;
                            end
                        end
                        else
                            recovery_ticks = 0;
                    end
                end
                else
                begin
                    recovery_ticks = 0;
                    if (alert_ticks == 0)
                        alert_ticks = 1;
                    if (ev.battery_fault && alert_ticks > RampFaultLag)
                        verdict.action = blvp_pkg::ACT_OFF;
                    else if (alert_ticks > cfg_alert_delay)
                    begin
                        if (ramp_cur > DropCurMin)
                            ramp_cur -= DropCur;
                        if (ramp_volt > DropVoltMin)
                            ramp_volt -= DropVolt;
                        alert_ticks = 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        verdict.current_limit_ma = ramp_cur[blvp_pkg::CurW-1:0];
        verdict.volt_threshold_mv = ramp_volt[blvp_pkg::VoltW-1:0];
        return verdict;
    endfunction

    function automatic blvp_pkg::item_t event_of(blvp_pkg::kind_t k, bit alert, bit fault,
                                                 bit ample, bit pressed, bit held,
                                                 bit shutoff, logic [7:0] jump,
                                                 logic [14:0] cur_ceiling,
                                                 logic [12:0] volt_ceiling);
        blvp_pkg::item_t ev;
        ev.kind = k;
        ev.battery_alert = alert;
        ev.battery_fault = fault;
        ev.battery_ample = ample;
        ev.key_pressed_event = pressed;
        ev.key_hold_event = held;
        ev.need_shutoff = shutoff;
        ev.jump_mode = jump;
        ev.mode_current_ma = cur_ceiling;
        ev.mode_volt_threshold = volt_ceiling;
        return ev;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Register write over the configuration port; the copy follows the DUT.
    task automatic apb_write(blvp_pkg::reg_idx_t idx, int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            blvp_pkg::REG_ALERT_DELAY: cfg_alert_delay = value & 'h7F;
            blvp_pkg::REG_FAULT_DELAY: cfg_fault_delay = value & 'h7F;
            blvp_pkg::REG_INIT_CUR:    ramp_cur = value & CurTop;
            blvp_pkg::REG_INIT_VOLT:   ramp_volt = value & VoltTop;
        endcase
    endtask

    task automatic apply_config(int alert_delay, int fault_delay, int init_cur, int init_volt);
        apb_write(blvp_pkg::REG_ALERT_DELAY, alert_delay);
        apb_write(blvp_pkg::REG_FAULT_DELAY, fault_delay);
        apb_write(blvp_pkg::REG_INIT_CUR, init_cur);
        apb_write(blvp_pkg::REG_INIT_VOLT, init_volt);
    endtask

    // Holds the stimulus back until every verdict has come out.
    task automatic wait_idle();
        while (pending_events.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random events in bursts that keep one battery condition, so that the
    // timers get the ticks they need to run out. Some bursts are pure noise.
    task automatic queue_random_events(int count);
        int              left;
        int              burst;
        int              tick_pct;
        int              cond;
        int              pick;
        bit              noise;
        bit              alert;
        bit              fault;
        bit              ample;
        logic [14:0]     cur_ceiling;
        logic [12:0]     volt_ceiling;
        logic [63:0]     raw;
        blvp_pkg::kind_t k;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(4, 24);
            tick_pct = $urandom_range(30, 80);
            cond = $urandom_range(0, 9);
            noise = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 2))
                0: cur_ceiling = 15'($urandom);
                1: cur_ceiling = 15'($urandom_range(0, 8000));
                default: cur_ceiling = 15'h7FFF;
            endcase
            case ($urandom_range(0, 2))
                0: volt_ceiling = 13'($urandom);
                1: volt_ceiling = 13'($urandom_range(2700, 3400));
                default: volt_ceiling = 13'h1FFF;
            endcase
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if (noise)
                begin
                    raw = {$urandom, $urandom};
                    pending_events.push_back(raw[$bits(blvp_pkg::item_t)-1:0]);
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3)
                        k = blvp_pkg::KIND_NONE;
                    else if (pick < tick_pct)
                        k = blvp_pkg::KIND_TICK;
                    else if (pick[0])
                        k = blvp_pkg::KIND_GEAR;
                    else
                        k = blvp_pkg::KIND_RAMP;
                    alert = (cond >= 5 && cond <= 7) || (cond >= 8 && $urandom_range(0, 1));
                    fault = (cond >= 8);
                    ample = (cond <= 3);
                    // Occasional flag flips break the burst's condition.
                    if ($urandom_range(0, 11) == 0)
                        alert = !alert;
                    if ($urandom_range(0, 11) == 0)
                        fault = !fault;
                    if ($urandom_range(0, 11) == 0)
                        ample = !ample;
                    pending_events.push_back(event_of(k, alert, fault, ample,
                        $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0,
                        $urandom_range(0, 2) == 0, 8'($urandom), cur_ceiling,
                        volt_ceiling));
                end
                left--;
            end
        end
    endtask

    // One configuration, then random events with a full drain halfway through.
    task automatic run_random_phase(int alert_delay, int fault_delay, int init_cur,
                                    int init_volt, int count);
        apply_config(alert_delay, fault_delay, init_cur, init_volt);
        queue_random_events(count / 2);
        wait_idle();
        queue_random_events(count - count / 2);
        wait_idle();
    endtask

    // Stream driver: offers the next pending event and predicts on acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_verdicts.push_back(predict_protection(driven_event));
            if (!s_tvalid || s_tready)
            begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    driven_event = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= driven_event.kind;
                    s_tdata <= {6'b0, driven_event.mode_volt_threshold,
                                driven_event.mode_current_ma, driven_event.jump_mode,
                                driven_event.need_shutoff, driven_event.key_hold_event,
                                driven_event.key_pressed_event, driven_event.battery_ample,
                                driven_event.battery_fault, driven_event.battery_alert};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each accepted result against the oldest verdict.
    always @(posedge clk)
    begin : result_monitor
        blvp_pkg::result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                    note_mismatch("unexpected result (action)", -1, int'(m_tuser));
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_tuser !== want.action)
                        note_mismatch("action", int'(want.action), int'(m_tuser));
                    if (m_tdata[7:0] !== want.target_mode)
                        note_mismatch("target_mode", int'(want.target_mode),
                                      int'(m_tdata[7:0]));
                    if (m_tdata[22:8] !== want.current_limit_ma)
                        note_mismatch("current_limit_ma", int'(want.current_limit_ma),
                                      int'(m_tdata[22:8]));
                    if (m_tdata[35:23] !== want.volt_threshold_mv)
                        note_mismatch("volt_threshold_mv", int'(want.volt_threshold_mv),
                                      int'(m_tdata[35:23]));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus sequence.
    initial
    begin
        send_idle_pct = 28;
        recv_idle_pct = 87;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults of the registers and of the ramp state.
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 0, 0, 1, 0, 0, 0, 8'd0,
                                          15'h7FFF, 13'h1FFF));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        wait_idle();

        // Directed corner cases with short delays.
        apply_config(1, 0, 32700, 8180);
        // Unknown kind changes nothing.
        pending_events.push_back(event_of(blvp_pkg::KIND_NONE, 1, 1, 1, 1, 1, 1, 8'hFF,
                                          15'h7FFF, 13'h1FFF));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        // Raise that saturates both values, then a ceiling already reached.
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 0, 0, 1, 0, 0, 0, 8'd0,
                                          15'h7FFF, 13'h1FFF));
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 0, 0, 1, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        // Alert timer runs up to its limit, then the gear check steps down.
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 0, 0, 0, 8'hFF,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 0, 0, 0, 8'hFF,
                                          15'd0, 13'd0));
        // Press without hold is no gear change; press with hold stops the timer.
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 1, 0, 0, 8'h5A,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 1, 1, 0, 8'hA5,
                                          15'd0, 13'd0));
        // Fault in a mode that shuts off, and fault during a gear change.
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 0, 1, 0, 0, 0, 1, 8'd3,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 1, 0, 1, 1, 0, 8'd4,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 0, 1, 0, 0, 0, 0, 8'd7,
                                          15'd0, 13'd0));
        // Ramp drop under a lasting alert.
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 1, 1, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        // Recovery: the threshold clamps to its ceiling, the current overshoots.
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 0, 0, 1, 0, 0, 0, 8'd0,
                                          15'd32600, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_RAMP, 0, 0, 1, 0, 0, 0, 8'd0,
                                          15'h7FFF, 13'h1FFF));
        wait_idle();

        // Long delays: the alert timer has to count all the way up.
        apply_config(125, 125, 32767, 8191);
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 0, 0, 0, 8'd0,
                                          15'd0, 13'd0));
        repeat (127)
            pending_events.push_back(event_of(blvp_pkg::KIND_TICK, 1, 0, 0, 0, 0, 0, 8'd0,
                                              15'd0, 13'd0));
        pending_events.push_back(event_of(blvp_pkg::KIND_GEAR, 1, 0, 0, 0, 0, 0, 8'h81,
                                          15'd0, 13'd0));
        wait_idle();
        queue_random_events(40);
        wait_idle();

        run_random_phase($urandom_range(1, 12), $urandom_range(0, 8), $urandom_range(0, 32767),
                         $urandom_range(0, 8191), 60);

        send_idle_pct = 87;
        recv_idle_pct = 28;
        run_random_phase($urandom_range(1, 12), $urandom_range(0, 8), $urandom_range(0, 32767),
                         $urandom_range(0, 8191), 70);
        run_random_phase($urandom_range(4, 10), $urandom_range(0, 125), $urandom_range(0, 6000),
                         $urandom_range(2600, 3400), 70);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase($urandom_range(1, 125), $urandom_range(0, 125),
                         $urandom_range(0, 32767), $urandom_range(0, 8191), 70);
        run_random_phase(4, 0, 0, 0, 70);

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_battery_low_voltage_protector OK");
        else
            $display("tb_battery_low_voltage_protector NOT OK");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("tb_battery_low_voltage_protector NOT OK");
        $finish;
    end

endmodule

FILE: files.f
sv/blvp_pkg.sv
sv/blvp_regs.sv
sv/blvp_core.sv
sv/battery_low_voltage_protector.sv
sv/blvp_checker.sv
dv/tb_battery_low_voltage_protector.sv
